>>> rtl/core/vnkd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vnkd_pkg;

  // Result status codes.
  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_SHORT     = 3'd1;
  localparam logic [2:0] STATUS_BAD_TYPE  = 3'd2;
  localparam logic [2:0] STATUS_LEN_OVER  = 3'd3;
  localparam logic [2:0] STATUS_TRUNCATED = 3'd4;

  // Route distinguisher types.
  localparam logic [15:0] RD_TYPE_0 = 16'h0000;
  localparam logic [15:0] RD_TYPE_1 = 16'h0001;
  localparam logic [15:0] RD_TYPE_2 = 16'h0002;

  // Byte positions within the key.
  localparam logic [4:0] IDX_ADMIN    = 5'd2;
  localparam logic [4:0] IDX_ASSIGNED = 5'd6;
  localparam logic [4:0] IDX_LENGTH   = 5'd8;
  localparam logic [4:0] IDX_MAX      = 5'd31;

  localparam logic [6:0] MIN_KEY_BYTES  = 7'd9;
  localparam logic [6:0] LABEL_END      = 7'd12;
  localparam logic [7:0] MAX_PREFIX_LEN = 8'd32;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  count;
    logic [15:0] rd_type;
    logic [31:0] admin;
    logic [15:0] assigned;
    logic [7:0]  length;
    logic [31:0] prefix;
    logic [23:0] label;
  } key_fields_t;

  // Number of prefix bytes carried for a given length byte.
  function automatic logic [5:0] prefix_byte_count(input logic [7:0] len);
    logic [8:0] sum;
    begin
      sum = {1'b0, len} + 9'd7;
      prefix_byte_count = sum[8:3];
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/vnkd_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module vnkd_in_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_last_byte,
  output logic                   in_stall,
  input  wire logic              advance,
  output logic                   item_valid,
  output vnkd_pkg::in_item_t     item
);

  logic               valid_r;
  logic               valid_nxt;
  vnkd_pkg::in_item_t item_r;
  logic               accept;

  assign in_stall = valid_r & ~advance;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.data <= in_byte;
      item_r.last <= in_last_byte;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

>>> rtl/core/vnkd_field_accum.sv
`timescale 1ns / 1ps
`default_nettype none

module vnkd_field_accum (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire vnkd_pkg::in_item_t item,
  output vnkd_pkg::key_fields_t  fields_nxt
);

  vnkd_pkg::key_fields_t fields_r;
  logic [5:0]            nb;
  logic [6:0]            idx_w;
  logic [6:0]            prefix_end;
  logic [6:0]            label_end;

  assign nb         = vnkd_pkg::prefix_byte_count(fields_r.length);
  assign idx_w      = {2'b00, fields_r.count};
  assign prefix_end = vnkd_pkg::MIN_KEY_BYTES + {1'b0, nb};
  assign label_end  = vnkd_pkg::LABEL_END + {1'b0, nb};

  // Each byte lands in at most one field, chosen by its position in the key.
  always_comb begin
    fields_nxt = fields_r;
    if (fields_r.count < vnkd_pkg::IDX_ADMIN) begin
      fields_nxt.rd_type = {fields_r.rd_type[7:0], item.data};
    end else if (fields_r.count < vnkd_pkg::IDX_ASSIGNED) begin
      fields_nxt.admin = {fields_r.admin[23:0], item.data};
    end else if (fields_r.count < vnkd_pkg::IDX_LENGTH) begin
      fields_nxt.assigned = {fields_r.assigned[7:0], item.data};
    end else if (fields_r.count == vnkd_pkg::IDX_LENGTH) begin
      fields_nxt.length = item.data;
    end else if (idx_w < prefix_end) begin
      fields_nxt.prefix = {fields_r.prefix[23:0], item.data};
    end else if (idx_w < label_end) begin
      fields_nxt.label = {fields_r.label[15:0], item.data};
    end
    if (fields_r.count != vnkd_pkg::IDX_MAX) begin
      fields_nxt.count = fields_r.count + 5'd1;
    end
  end

  // The state clears after the final byte so the next key starts fresh.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fields_r <= '0;
    end else if (step) begin
      if (item.last) begin
        fields_r <= '0;
      end else begin
        fields_r <= fields_nxt;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/vnkd_result.sv
`timescale 1ns / 1ps
`default_nettype none

module vnkd_result (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire vnkd_pkg::key_fields_t fields,
  output logic                   ready,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [2:0]             out_status,
  output logic [15:0]            out_rd_type,
  output logic [31:0]            out_rd_admin,
  output logic [15:0]            out_rd_assigned,
  output logic [7:0]             out_prefix_length,
  output logic [31:0]            out_prefix_addr,
  output logic                   out_label_valid,
  output logic [19:0]            out_mpls_label
);

  logic        valid_r;
  logic        valid_nxt;
  logic [2:0]  status_nxt;
  logic [15:0] rd_type_nxt;
  logic [31:0] admin_nxt;
  logic [15:0] assigned_nxt;
  logic [7:0]  length_nxt;
  logic [31:0] prefix_nxt;
  logic        lvalid_nxt;
  logic [19:0] label_nxt;
  logic [2:0]  status_r;
  logic [15:0] rd_type_r;
  logic [31:0] admin_r;
  logic [15:0] assigned_r;
  logic [7:0]  length_r;
  logic [31:0] prefix_r;
  logic        lvalid_r;
  logic [19:0] label_r;
  logic [5:0]  nb;
  logic [6:0]  n_w;

  assign nb  = vnkd_pkg::prefix_byte_count(fields.length);
  assign n_w = {2'b00, fields.count};

  always_comb begin
    status_nxt   = vnkd_pkg::STATUS_OK;
    rd_type_nxt  = '0;
    admin_nxt    = '0;
    assigned_nxt = '0;
    length_nxt   = '0;
    prefix_nxt   = '0;
    lvalid_nxt   = 1'b0;
    label_nxt    = '0;
    if (n_w < vnkd_pkg::MIN_KEY_BYTES) begin
      status_nxt = vnkd_pkg::STATUS_SHORT;
    end else if (fields.rd_type != vnkd_pkg::RD_TYPE_0 &&
                 fields.rd_type != vnkd_pkg::RD_TYPE_1 &&
                 fields.rd_type != vnkd_pkg::RD_TYPE_2) begin
      status_nxt  = vnkd_pkg::STATUS_BAD_TYPE;
      rd_type_nxt = fields.rd_type;
    end else begin
      rd_type_nxt = fields.rd_type;
      // A type-0 distinguisher reports only the two bytes after the type.
      if (fields.rd_type == vnkd_pkg::RD_TYPE_0) begin
        admin_nxt = {16'h0000, fields.admin[31:16]};
      end else begin
        admin_nxt = fields.admin;
      end
      assigned_nxt = fields.assigned;
      length_nxt   = fields.length;
      if (fields.length > vnkd_pkg::MAX_PREFIX_LEN) begin
        status_nxt = vnkd_pkg::STATUS_LEN_OVER;
      end else if (n_w < vnkd_pkg::MIN_KEY_BYTES + {1'b0, nb}) begin
        status_nxt = vnkd_pkg::STATUS_TRUNCATED;
      end else begin
        case (nb)
          6'd1:    prefix_nxt = {fields.prefix[7:0], 24'h000000};
          6'd2:    prefix_nxt = {fields.prefix[15:0], 16'h0000};
          6'd3:    prefix_nxt = {fields.prefix[23:0], 8'h00};
          6'd4:    prefix_nxt = fields.prefix;
          default: prefix_nxt = '0;
        endcase
        lvalid_nxt = (n_w >= vnkd_pkg::LABEL_END + {1'b0, nb});
        if (lvalid_nxt) begin
          label_nxt = fields.label[23:4];
        end
      end
    end
  end

  assign ready = ~valid_r | ~out_stall;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_stall) begin
      valid_nxt = valid_r;
    end else begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r   <= status_nxt;
      rd_type_r  <= rd_type_nxt;
      admin_r    <= admin_nxt;
      assigned_r <= assigned_nxt;
      length_r   <= length_nxt;
      prefix_r   <= prefix_nxt;
      lvalid_r   <= lvalid_nxt;
      label_r    <= label_nxt;
    end
  end

  assign out_valid         = valid_r;
  assign out_status        = status_r;
  assign out_rd_type       = rd_type_r;
  assign out_rd_admin      = admin_r;
  assign out_rd_assigned   = assigned_r;
  assign out_prefix_length = length_r;
  assign out_prefix_addr   = prefix_r;
  assign out_label_valid   = lvalid_r;
  assign out_mpls_label    = label_r;

endmodule

`default_nettype wire

>>> rtl/core/vpnv4_nlri_key_decoder.sv
// VPNv4 NLRI key decoder.
// Input channel (in_valid / in_stall): one byte of the key per transaction in
// in_byte, with in_last_byte high on the final byte of a key. The key is an
// 8-byte route distinguisher, a prefix-length byte, the prefix bytes and an
// optional 3-byte label; bytes after the label are ignored.
// Result channel (out_valid / out_stall): one transaction per key, produced
// by its last byte, carrying the status and the decoded fields.
// Throughput is one byte per cycle while in_stall is low. A byte passes an
// input register and the field accumulators; the last byte of a key goes from
// the input register into the result register, which drives the outputs.
// When the receiver stalls, the result register holds its transaction. Bytes
// that are not the last of a key keep flowing; a last byte waits in the input
// register until the result register is free, and in_stall stays high toward
// the sender while it waits.
// Reset (rst_n low at a clock edge) empties both registers and clears the
// accumulators, so the first byte after reset starts a new key.
`timescale 1ns / 1ps
`default_nettype none

module vpnv4_nlri_key_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [15:0]      out_rd_type,
  output logic [31:0]      out_rd_admin,
  output logic [15:0]      out_rd_assigned,
  output logic [7:0]       out_prefix_length,
  output logic [31:0]      out_prefix_addr,
  output logic             out_label_valid,
  output logic [19:0]      out_mpls_label
);

  vnkd_pkg::in_item_t    item;
  vnkd_pkg::key_fields_t fields_nxt;
  logic                  item_valid;
  logic                  advance;
  logic                  step;
  logic                  res_ready;

  // Only a final byte needs room in the result register.
  assign advance = ~item.last | res_ready;
  assign step    = item_valid & advance;

  vnkd_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_byte      (in_byte),
    .in_last_byte (in_last_byte),
    .in_stall     (in_stall),
    .advance      (advance),
    .item_valid   (item_valid),
    .item         (item)
  );

  vnkd_field_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .item       (item),
    .fields_nxt (fields_nxt)
  );

  vnkd_result u_result (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (step & item.last),
    .fields            (fields_nxt),
    .ready             (res_ready),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_rd_type       (out_rd_type),
    .out_rd_admin      (out_rd_admin),
    .out_rd_assigned   (out_rd_assigned),
    .out_prefix_length (out_prefix_length),
    .out_prefix_addr   (out_prefix_addr),
    .out_label_valid   (out_label_valid),
    .out_mpls_label    (out_mpls_label)
  );

endmodule

`default_nettype wire

>>> rtl/core/vnkd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module vnkd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  out_status,
  input wire logic [15:0] out_rd_type,
  input wire logic [7:0]  out_prefix_length,
  input wire logic        out_label_valid,
  input wire logic [19:0] out_mpls_label
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
    $stable(out_rd_type) && $stable(out_mpls_label))
    else $error("stalled result transaction changed");

  // Back pressure toward the sender only comes from a blocked result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result register was free");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == vnkd_pkg::STATUS_SHORT |->
    out_rd_type == 16'h0000 && out_prefix_length == 8'h00 && !out_label_valid)
    else $error("short key reported decoded fields");

  a_label_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !(out_status == vnkd_pkg::STATUS_OK) |->
    !out_label_valid && out_mpls_label == 20'h00000)
    else $error("label reported on a failed key");

endmodule

bind vpnv4_nlri_key_decoder vnkd_checker u_vnkd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_rd_type       (out_rd_type),
  .out_prefix_length (out_prefix_length),
  .out_label_valid   (out_label_valid),
  .out_mpls_label    (out_mpls_label)
);

`default_nettype wire
